// File: src/acc_pkg.sv
// ----------------------------------------------------------------------------
// acc_pkg
// Shared types and constants for the address claim controller: item
// structs, opcode and phase codes, configuration bundle, group numbers.
// ----------------------------------------------------------------------------
`default_nettype none

package acc_pkg;

	localparam int unsigned AddrLimitInt = 252;
	localparam logic [7:0] ADDRESS_LIMIT = 8'(AddrLimitInt);
	localparam logic [7:0] START_ADDR_RESET = 8'h80;
	localparam logic [7:0] WAIT_TICKS_RESET = 8'd1;
	localparam logic [7:0] GLOBAL_DEST = 8'hFF;
	localparam logic [7:0] WAIT_COUNT_MAX = 8'hFF;
	localparam logic [17:0] GROUP_CLAIM = 18'h0EE00;
	localparam logic [17:0] GROUP_REQUEST = 18'h0EA00;
	localparam logic [3:0] MIN_REQUEST_LEN = 4'd3;

	localparam int unsigned PADDR_W = 5;
	localparam int unsigned PDATA_W = 64;

	typedef enum logic [1:0] {
		REG_OWN_NAME = 2'd0,
		REG_START_ADDRESS = 2'd1,
		REG_CLAIM_WAIT_TICKS = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_FRAME = 2'd1,
		OP_SENT_OK = 2'd2,
		OP_SEND_FAIL = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		PH_PENDING = 2'd0,
		PH_CLAIMING = 2'd1,
		PH_CLAIMED = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic frame_is_pdu1;
		logic [7:0] frame_dest;
		logic [7:0] frame_source;
		logic [17:0] frame_group;
		logic [3:0] frame_length;
		logic [63:0] frame_payload;
	} in_item_t;

	typedef struct packed {
		logic send_claim;
		logic [7:0] current_address;
		logic [1:0] phase_out;
		logic lost_contest;
		logic request_seen;
		logic [23:0] requested_group;
		logic forward_frame;
	} out_item_t;

	typedef struct packed {
		logic [63:0] own_name;
		logic [7:0] start_address;
		logic [7:0] claim_wait_ticks;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic [7:0] address;
	} addr_load_t;

	typedef struct packed {
		phase_t phase;
		logic [7:0] own_address;
		logic [7:0] wait_count;
	} claim_state_t;

endpackage

`default_nettype wire

// File: src/acc_cfg_regs.sv
// ----------------------------------------------------------------------------
// acc_cfg_regs
// Register file behind the APB port; a start address write also reloads
// the own address.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_cfg_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [acc_pkg::PADDR_W-1:0] paddr,
	input wire logic [acc_pkg::PDATA_W-1:0] pwdata,
	output logic [acc_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	output acc_pkg::cfg_t cfg,
	output acc_pkg::addr_load_t addr_load
);
	import acc_pkg::*;

	logic wr_en;
	reg_idx_t idx;
	cfg_t cfg_q;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign idx = reg_idx_t'(paddr[4:3]);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_name <= '0;
			cfg_q.start_address <= START_ADDR_RESET;
			cfg_q.claim_wait_ticks <= WAIT_TICKS_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_OWN_NAME: cfg_q.own_name <= pwdata;
				REG_START_ADDRESS: cfg_q.start_address <= pwdata[7:0];
				REG_CLAIM_WAIT_TICKS: cfg_q.claim_wait_ticks <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// out-of-range start address falls back to zero
	always_comb begin
		addr_load.load = wr_en && (idx == REG_START_ADDRESS);
		addr_load.address = (pwdata[7:0] >= ADDRESS_LIMIT) ? 8'd0 : pwdata[7:0];
	end

	always_comb begin
		unique case (idx)
			REG_OWN_NAME: prdata = cfg_q.own_name;
			REG_START_ADDRESS: prdata = {56'd0, cfg_q.start_address};
			REG_CLAIM_WAIT_TICKS: prdata = {56'd0, cfg_q.claim_wait_ticks};
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: src/acc_step.sv
// ----------------------------------------------------------------------------
// acc_step
// Per-item decision logic: next claim state and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_step (
	input wire acc_pkg::in_item_t item,
	input wire acc_pkg::claim_state_t cur,
	input wire acc_pkg::cfg_t cfg,
	output acc_pkg::claim_state_t nxt,
	output acc_pkg::out_item_t result
);
	import acc_pkg::*;

	opcode_t op;
	logic [7:0] wait_inc;
	logic [8:0] addr_inc;
	logic [7:0] addr_next;
	logic frame_ok;
	logic claim_from_us;
	logic name_lower;
	logic is_claim;
	logic is_request;

	assign op = opcode_t'(item.opcode);
	assign wait_inc = (cur.wait_count < WAIT_COUNT_MAX) ? cur.wait_count + 8'd1 : cur.wait_count;
	assign addr_inc = {1'b0, cur.own_address} + 9'd1;
	assign addr_next = (addr_inc >= {1'b0, ADDRESS_LIMIT}) ? 8'd0 : addr_inc[7:0];
	assign frame_ok = (cur.phase != PH_PENDING) && !(item.frame_is_pdu1
		&& item.frame_dest != cur.own_address && item.frame_dest != GLOBAL_DEST);
	assign is_claim = item.frame_group == GROUP_CLAIM;
	assign is_request = item.frame_group == GROUP_REQUEST;
	assign claim_from_us = frame_ok && is_claim && (item.frame_source == cur.own_address);
	assign name_lower = item.frame_payload < cfg.own_name;

	// next state
	always_comb begin
		nxt = cur;
		unique case (op)
			OP_TICK: begin
				if (cur.phase == PH_CLAIMING) begin
					nxt.wait_count = wait_inc;
					if (wait_inc >= cfg.claim_wait_ticks)
						nxt.phase = PH_CLAIMED;
				end
			end
			OP_SENT_OK: begin
				if (cur.phase == PH_PENDING) begin
					nxt.phase = PH_CLAIMING;
					nxt.wait_count = '0;
				end
			end
			OP_SEND_FAIL: nxt.phase = PH_PENDING;
			OP_FRAME: begin
				if (claim_from_us && name_lower) begin
					nxt.own_address = addr_next;
					nxt.phase = PH_PENDING;
				end
			end
			default: ;
		endcase
	end

	// result flags
	always_comb begin
		result = '0;
		result.current_address = nxt.own_address;
		result.phase_out = nxt.phase;
		unique case (op)
			OP_TICK: result.send_claim = cur.phase == PH_PENDING;
			OP_FRAME: begin
				result.lost_contest = claim_from_us && name_lower;
				result.send_claim = claim_from_us && !name_lower;
				if (frame_ok && is_request && item.frame_length >= MIN_REQUEST_LEN) begin
					result.request_seen = 1'b1;
					result.requested_group = item.frame_payload[23:0];
				end
				result.forward_frame = frame_ok && !is_claim && !is_request;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: src/can_address_claim_controller_core.sv
// ----------------------------------------------------------------------------
// can_address_claim_controller_core
// Address claim controller for a CAN node: arbitrates its source address
// by NAME, defends it, and sorts received frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries one item per
//   accepted cycle: a timer tick, a received frame, or a claim send outcome.
//   Output channel (out_valid / out_stall / out_item) returns exactly one
//   result item per input item, in order.
//   Path: an accepted item passes the input register, then the result
//   register, before its result shows on the output.
//   Throughput: one item per cycle while out_stall is low; the decision is
//   one short pass of compare and increment logic between the two registers.
//   Stall: while out_stall holds a waiting result, the input register keeps
//   one more item and then in_stall rises; nothing is dropped.
//   Reset (arst_n low): phase pending, own address 128, wait count 0,
//   own_name 0, start_address 128, claim_wait_ticks 1, both channels empty.
//   Configuration goes through the APB port (64-bit data, registers at byte
//   offsets 0, 8, 16); write it only while the block is idle. A start
//   address write reloads the own address at once.
// ----------------------------------------------------------------------------
`default_nettype none

module can_address_claim_controller_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire acc_pkg::in_item_t in_item,
	output logic out_valid,
	input wire logic out_stall,
	output acc_pkg::out_item_t out_item,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [acc_pkg::PADDR_W-1:0] paddr,
	input wire logic [acc_pkg::PDATA_W-1:0] pwdata,
	output logic [acc_pkg::PDATA_W-1:0] prdata,
	output logic pready
);
	import acc_pkg::*;

	cfg_t cfg;
	addr_load_t addr_load;

	logic valid_s1;
	in_item_t item_s1;
	logic valid_s2;
	out_item_t item_s2;

	claim_state_t state_q;
	claim_state_t state_nxt;
	out_item_t result;

	logic advance;

	acc_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg),
		.addr_load(addr_load)
	);

	acc_step u_step (
		.item(item_s1),
		.cur(state_q),
		.cfg(cfg),
		.nxt(state_nxt),
		.result(result)
	);

	// advance the input stage whenever the result register is free or drains
	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_item;
	end

	// result register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			item_s2 <= result;
	end

	// claim state: commit the step as its result moves into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= PH_PENDING;
			state_q.own_address <= START_ADDR_RESET;
			state_q.wait_count <= '0;
		end else if (addr_load.load) begin
			state_q.own_address <= addr_load.address;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_item = item_s2;

endmodule

`default_nettype wire

// File: src/acc_checker.sv
// ----------------------------------------------------------------------------
// acc_checker
// Port-level checks on the address claim controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire acc_pkg::out_item_t out_item
);
	import acc_pkg::*;

	// stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// losing a contest drops back to pending without a claim
	a_lost_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.lost_contest |->
			out_item.phase_out == PH_PENDING && !out_item.send_claim)
		else $error("lost contest without returning to pending");

	a_req_group_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.request_seen |-> out_item.requested_group == '0)
		else $error("requested group set without a request");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.current_address < ADDRESS_LIMIT)
		else $error("own address beyond the address limit");

endmodule

bind can_address_claim_controller_core acc_checker u_acc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_item(out_item)
);

`default_nettype wire
